// File: rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared types, defaults and codes for the segment intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sgi_pkg;

	localparam int COORD_BITS_D = 24;
	localparam int FRAC_BITS_D  = 8;
	localparam int OUT_W        = 32;

	localparam int OUT_MAX = 2147483647;
	localparam int OUT_MIN = -2147483647 - 1;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_PARALLEL = 3'd1,
		ST_OUT_A    = 3'd2,
		ST_OUT_B    = 3'd3,
		ST_SAT      = 3'd4
	} sgi_status_t;

	// slots of the geometry bundle carried beside the arithmetic
	localparam int G_X1    = 0;
	localparam int G_Y1    = 1;
	localparam int G_AXLO  = 2;
	localparam int G_AXHI  = 3;
	localparam int G_AYLO  = 4;
	localparam int G_AYHI  = 5;
	localparam int G_BXLO  = 6;
	localparam int G_BXHI  = 7;
	localparam int G_BYLO  = 8;
	localparam int G_BYHI  = 9;
	localparam int G_SLOTS = 10;

	typedef struct packed {
		logic zero;   // r2 == 0, lines parallel
		logic neg_x;  // sign of x quotient
		logic neg_y;  // sign of y quotient
	} sgi_ctl_t;

endpackage

`default_nettype wire

// File: rtl/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// Intersection of two 2D segments (or their lines) in Q.FRAC_BITS fixed point.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | ax ay bx by_coord cx cy dx dy
//  out     | out_valid / out_stall  | cross_x cross_y status is_hit
//  cfg     | cfg_wen                | cfg_wdata (segment_mode)
//
// One beat enters per cycle while the pipe is not held; QB, the divider's
// quotient width, is max(COORD_BITS+FRAC_BITS, 32) + 1, and the divider
// yields one quotient bit per stage.
// All stages move together; the pipe holds only while the output register
// is full and stalled, so in_stall follows out_stall through that register.
// Reset clears every valid bit and sets segment mode.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection import sgi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_D,
	parameter int FRAC_BITS  = FRAC_BITS_D
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wen,
	input  wire logic                         cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by_coord,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	input  wire logic signed [COORD_BITS-1:0] dx,
	input  wire logic signed [COORD_BITS-1:0] dy,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [OUT_W-1:0]           cross_x,
	output logic signed [OUT_W-1:0]           cross_y,
	output logic [2:0]                        status,
	output logic                              is_hit
);

	localparam int C  = COORD_BITS;
	localparam int QB = ((C + FRAC_BITS > 32) ? C + FRAC_BITS : 32) + 1;

	logic     seg_mode_q;
	logic     adv;

	logic                          f_v;
	sgi_ctl_t                      f_ctl;
	logic [G_SLOTS-1:0][C-1:0]     f_geo;
	logic [3*C+3:0]                f_nx, f_ny;
	logic [2*C+2:0]                f_den;

	logic                          d_v;
	sgi_ctl_t                      d_ctl;
	logic [G_SLOTS-1:0][C-1:0]     d_geo;
	logic                          d_ovx, d_ovy;
	logic [QB-1:0]                 d_qx, d_qy;

	// whole pipe advances unless a finished beat is held at the output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_mode_q <= 1'b1;
		end else if (cfg_wen) begin
			seg_mode_q <= cfg_wdata;
		end
	end

	sgi_front #(.COORD_BITS(C)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (in_valid),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by_coord (by_coord),
		.cx       (cx),
		.cy       (cy),
		.dx       (dx),
		.dy       (dy),
		.out_v    (f_v),
		.out_ctl  (f_ctl),
		.out_geo  (f_geo),
		.num_x    (f_nx),
		.num_y    (f_ny),
		.den      (f_den)
	);

	sgi_divider #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (f_v),
		.in_ctl  (f_ctl),
		.in_geo  (f_geo),
		.num_x   (f_nx),
		.num_y   (f_ny),
		.den     (f_den),
		.out_v   (d_v),
		.out_ctl (d_ctl),
		.out_geo (d_geo),
		.ov_x    (d_ovx),
		.ov_y    (d_ovy),
		.q_x     (d_qx),
		.q_y     (d_qy)
	);

	sgi_back #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.seg_mode (seg_mode_q),
		.in_v     (d_v),
		.in_ctl   (d_ctl),
		.in_geo   (d_geo),
		.ov_x     (d_ovx),
		.ov_y     (d_ovy),
		.q_x      (d_qx),
		.q_y      (d_qy),
		.out_v    (out_valid),
		.cross_x  (cross_x),
		.cross_y  (cross_y),
		.status   (status),
		.is_hit   (is_hit)
	);

endmodule

`default_nettype wire

// File: rtl/sgi_front.sv
// ----------------------------------------------------------------------------
// sgi_front
// Differences, cross products, magnitudes and split numerator products.
// Six register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_front import sgi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_D
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   adv,
	input  wire logic                                   in_v,
	input  wire logic signed [COORD_BITS-1:0]           ax,
	input  wire logic signed [COORD_BITS-1:0]           ay,
	input  wire logic signed [COORD_BITS-1:0]           bx,
	input  wire logic signed [COORD_BITS-1:0]           by_coord,
	input  wire logic signed [COORD_BITS-1:0]           cx,
	input  wire logic signed [COORD_BITS-1:0]           cy,
	input  wire logic signed [COORD_BITS-1:0]           dx,
	input  wire logic signed [COORD_BITS-1:0]           dy,
	output logic                                        out_v,
	output sgi_ctl_t                                    out_ctl,
	output logic [G_SLOTS-1:0][COORD_BITS-1:0]          out_geo,
	output logic [3*COORD_BITS+3:0]                     num_x,
	output logic [3*COORD_BITS+3:0]                     num_y,
	output logic [2*COORD_BITS+2:0]                     den
);

	localparam int C  = COORD_BITS;
	localparam int E  = C + 1;
	localparam int DW = 2 * C + 3;
	localparam int LO = C + 2;
	localparam int HI = DW - LO;
	localparam int M  = DW + E;

	typedef logic [G_SLOTS-1:0][C-1:0] geo_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [E-1:0] ex_s1, ey_s1, fx_s1, fy_s1, gx_s1, gy_s1;
	geo_t                geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6;

	logic signed [2*E-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [E-1:0]   ex_s2, ey_s2, ex_s3, ey_s3;

	logic signed [DW-1:0] r1_s3, r2_s3;

	logic [DW-1:0] r1a_s4, r2a_s4, r2a_s5, r2a_s6;
	logic [E-1:0]  exa_s4, eya_s4;
	sgi_ctl_t      ctl_s4, ctl_s5, ctl_s6;

	logic [LO+E-1:0] xl_s5, yl_s5;
	logic [HI+E-1:0] xh_s5, yh_s5;

	logic [M-1:0] nx_s6, ny_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: edge vectors and box bounds
			ex_s1 <= E'(bx) - E'(ax);
			ey_s1 <= E'(by_coord) - E'(ay);
			fx_s1 <= E'(dx) - E'(cx);
			fy_s1 <= E'(dy) - E'(cy);
			gx_s1 <= E'(ax) - E'(cx);
			gy_s1 <= E'(ay) - E'(cy);
			geo_s1[G_X1]   <= ax;
			geo_s1[G_Y1]   <= ay;
			geo_s1[G_AXLO] <= (ax < bx) ? ax : bx;
			geo_s1[G_AXHI] <= (ax < bx) ? bx : ax;
			geo_s1[G_AYLO] <= (ay < by_coord) ? ay : by_coord;
			geo_s1[G_AYHI] <= (ay < by_coord) ? by_coord : ay;
			geo_s1[G_BXLO] <= (cx < dx) ? cx : dx;
			geo_s1[G_BXHI] <= (cx < dx) ? dx : cx;
			geo_s1[G_BYLO] <= (cy < dy) ? cy : dy;
			geo_s1[G_BYHI] <= (cy < dy) ? dy : cy;

			// s2: the four cross-product terms
			p1_s2  <= fx_s1 * gy_s1;
			p2_s2  <= fy_s1 * gx_s1;
			p3_s2  <= fy_s1 * ex_s1;
			p4_s2  <= fx_s1 * ey_s1;
			ex_s2  <= ex_s1;
			ey_s2  <= ey_s1;
			geo_s2 <= geo_s1;

			// s3: r1, r2
			r1_s3  <= DW'(p1_s2) - DW'(p2_s2);
			r2_s3  <= DW'(p3_s2) - DW'(p4_s2);
			ex_s3  <= ex_s2;
			ey_s3  <= ey_s2;
			geo_s3 <= geo_s2;

			// s4: magnitudes and quotient signs
			r1a_s4       <= r1_s3[DW-1] ? DW'(-r1_s3) : DW'(r1_s3);
			r2a_s4       <= r2_s3[DW-1] ? DW'(-r2_s3) : DW'(r2_s3);
			exa_s4       <= ex_s3[E-1] ? E'(-ex_s3) : E'(ex_s3);
			eya_s4       <= ey_s3[E-1] ? E'(-ey_s3) : E'(ey_s3);
			ctl_s4.zero  <= (r2_s3 == '0);
			ctl_s4.neg_x <= r1_s3[DW-1] ^ ex_s3[E-1] ^ r2_s3[DW-1];
			ctl_s4.neg_y <= r1_s3[DW-1] ^ ey_s3[E-1] ^ r2_s3[DW-1];
			geo_s4       <= geo_s3;

			// s5: partial products of r1 * e, r1 split in two halves
			xl_s5  <= (LO+E)'(r1a_s4[LO-1:0]) * (LO+E)'(exa_s4);
			xh_s5  <= (HI+E)'(r1a_s4[DW-1:LO]) * (HI+E)'(exa_s4);
			yl_s5  <= (LO+E)'(r1a_s4[LO-1:0]) * (LO+E)'(eya_s4);
			yh_s5  <= (HI+E)'(r1a_s4[DW-1:LO]) * (HI+E)'(eya_s4);
			r2a_s5 <= r2a_s4;
			ctl_s5 <= ctl_s4;
			geo_s5 <= geo_s4;

			// s6: recombine
			nx_s6  <= (M'(xh_s5) << LO) + M'(xl_s5);
			ny_s6  <= (M'(yh_s5) << LO) + M'(yl_s5);
			r2a_s6 <= r2a_s5;
			ctl_s6 <= ctl_s5;
			geo_s6 <= geo_s5;
		end
	end

	assign out_v   = v_s6;
	assign out_ctl = ctl_s6;
	assign out_geo = geo_s6;
	assign num_x   = nx_s6;
	assign num_y   = ny_s6;
	assign den     = r2a_s6;

endmodule

`default_nettype wire

// File: rtl/sgi_divider.sv
// ----------------------------------------------------------------------------
// sgi_divider
// Two-lane pipelined restoring divider, one quotient bit per stage, with an
// overflow stage up front that flags quotients too large for the output.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_divider import sgi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_D,
	parameter int FRAC_BITS  = FRAC_BITS_D
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                adv,
	input  wire logic                                                in_v,
	input  wire sgi_ctl_t                                            in_ctl,
	input  wire logic [G_SLOTS-1:0][COORD_BITS-1:0]                  in_geo,
	input  wire logic [3*COORD_BITS+3:0]                             num_x,
	input  wire logic [3*COORD_BITS+3:0]                             num_y,
	input  wire logic [2*COORD_BITS+2:0]                             den,
	output logic                                                     out_v,
	output sgi_ctl_t                                                 out_ctl,
	output logic [G_SLOTS-1:0][COORD_BITS-1:0]                       out_geo,
	output logic                                                     ov_x,
	output logic                                                     ov_y,
	output logic [((COORD_BITS+FRAC_BITS > 32) ? COORD_BITS+FRAC_BITS : 32):0] q_x,
	output logic [((COORD_BITS+FRAC_BITS > 32) ? COORD_BITS+FRAC_BITS : 32):0] q_y
);

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 3;
	localparam int M  = 3 * C + 4;
	localparam int NW = M + FRAC_BITS;
	localparam int QB = ((C + FRAC_BITS > 32) ? C + FRAC_BITS : 32) + 1;
	localparam int NP = NW + QB;

	typedef logic [G_SLOTS-1:0][C-1:0] geo_t;

	logic [NP-1:0] padx, pady;
	logic [NW-1:0] topx, topy;

	logic          v_s   [0:QB];
	sgi_ctl_t      ctl_s [0:QB];
	geo_t          geo_s [0:QB];
	logic          ovx_s [0:QB];
	logic          ovy_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic [DW-1:0] rx_s  [0:QB];
	logic [DW-1:0] ry_s  [0:QB];
	logic [QB-1:0] qx_s  [0:QB];
	logic [QB-1:0] qy_s  [0:QB];

	assign padx = NP'(NW'(num_x) << FRAC_BITS);
	assign pady = NP'(NW'(num_y) << FRAC_BITS);
	assign topx = NW'(padx >> QB);
	assign topy = NW'(pady >> QB);

	// entry stage: overflow check, remainder seeded with the high bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s[0] <= in_ctl;
			geo_s[0] <= in_geo;
			ovx_s[0] <= (topx >= NW'(den));
			ovy_s[0] <= (topy >= NW'(den));
			den_s[0] <= den;
			rx_s[0]  <= DW'(topx);
			ry_s[0]  <= DW'(topy);
			qx_s[0]  <= padx[QB-1:0];
			qy_s[0]  <= pady[QB-1:0];
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0] tx, ty;
		logic        gex, gey;

		assign tx  = {rx_s[k-1], qx_s[k-1][QB-1]};
		assign ty  = {ry_s[k-1], qy_s[k-1][QB-1]};
		assign gex = (tx >= (DW+1)'(den_s[k-1]));
		assign gey = (ty >= (DW+1)'(den_s[k-1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k] <= ctl_s[k-1];
				geo_s[k] <= geo_s[k-1];
				ovx_s[k] <= ovx_s[k-1];
				ovy_s[k] <= ovy_s[k-1];
				den_s[k] <= den_s[k-1];
				rx_s[k]  <= gex ? DW'(tx - (DW+1)'(den_s[k-1])) : DW'(tx);
				ry_s[k]  <= gey ? DW'(ty - (DW+1)'(den_s[k-1])) : DW'(ty);
				qx_s[k]  <= {qx_s[k-1][QB-2:0], gex};
				qy_s[k]  <= {qy_s[k-1][QB-2:0], gey};
			end
		end
	end

	assign out_v   = v_s[QB];
	assign out_ctl = ctl_s[QB];
	assign out_geo = geo_s[QB];
	assign ov_x    = ovx_s[QB];
	assign ov_y    = ovy_s[QB];
	assign q_x     = qx_s[QB];
	assign q_y     = qy_s[QB];

endmodule

`default_nettype wire

// File: rtl/sgi_back.sv
// ----------------------------------------------------------------------------
// sgi_back
// Signs the quotients, adds the start point, runs the box tests and
// saturation, and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_back import sgi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_D,
	parameter int FRAC_BITS  = FRAC_BITS_D
) (
	input  wire logic                                                clk,
	input  wire logic                                                arst_n,
	input  wire logic                                                adv,
	input  wire logic                                                seg_mode,
	input  wire logic                                                in_v,
	input  wire sgi_ctl_t                                            in_ctl,
	input  wire logic [G_SLOTS-1:0][COORD_BITS-1:0]                  in_geo,
	input  wire logic                                                ov_x,
	input  wire logic                                                ov_y,
	input  wire logic [((COORD_BITS+FRAC_BITS > 32) ? COORD_BITS+FRAC_BITS : 32):0] q_x,
	input  wire logic [((COORD_BITS+FRAC_BITS > 32) ? COORD_BITS+FRAC_BITS : 32):0] q_y,
	output logic                                                     out_v,
	output logic signed [OUT_W-1:0]                                  cross_x,
	output logic signed [OUT_W-1:0]                                  cross_y,
	output logic [2:0]                                               status,
	output logic                                                     is_hit
);

	localparam int C  = COORD_BITS;
	localparam int QB = ((C + FRAC_BITS > 32) ? C + FRAC_BITS : 32) + 1;
	localparam int PW = QB + 3;

	localparam logic signed [PW-1:0] SAT_HI = PW'(OUT_MAX);
	localparam logic signed [PW-1:0] SAT_LO = PW'(OUT_MIN);

	typedef logic [G_SLOTS-1:0][C-1:0] geo_t;

	logic                 v_b1, v_b2;
	sgi_ctl_t             ctl_b1, ctl_b2;
	geo_t                 geo_b1, geo_b2;
	logic signed [PW-1:0] qx_b1, qy_b1, ox_b1, oy_b1;
	logic signed [PW-1:0] px_b2, py_b2;

	logic [QB:0]          magx, magy;
	logic signed [PW-1:0] bnd [G_SLOTS];
	logic                 miss_a, miss_b, sx_hi, sx_lo, sy_hi, sy_lo;

	assign magx = ov_x ? ((QB+1)'(1) << QB) : q_x;
	assign magy = ov_y ? ((QB+1)'(1) << QB) : q_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1  <= 1'b0;
			v_b2  <= 1'b0;
			out_v <= 1'b0;
		end else if (adv) begin
			v_b1  <= in_v;
			v_b2  <= v_b1;
			out_v <= v_b2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// b1: signed quotient, start point scaled
			qx_b1  <= in_ctl.neg_x ? -$signed(PW'(magx)) : $signed(PW'(magx));
			qy_b1  <= in_ctl.neg_y ? -$signed(PW'(magy)) : $signed(PW'(magy));
			ox_b1  <= PW'($signed(in_geo[G_X1])) <<< FRAC_BITS;
			oy_b1  <= PW'($signed(in_geo[G_Y1])) <<< FRAC_BITS;
			ctl_b1 <= in_ctl;
			geo_b1 <= in_geo;

			// b2: point
			px_b2  <= ox_b1 + qx_b1;
			py_b2  <= oy_b1 + qy_b1;
			ctl_b2 <= ctl_b1;
			geo_b2 <= geo_b1;
		end
	end

	for (genvar g = 0; g < G_SLOTS; g++) begin : g_bnd
		assign bnd[g] = PW'($signed(geo_b2[g])) <<< FRAC_BITS;
	end

	assign miss_a = (px_b2 < bnd[G_AXLO]) || (px_b2 > bnd[G_AXHI]) ||
	                (py_b2 < bnd[G_AYLO]) || (py_b2 > bnd[G_AYHI]);
	assign miss_b = (px_b2 < bnd[G_BXLO]) || (px_b2 > bnd[G_BXHI]) ||
	                (py_b2 < bnd[G_BYLO]) || (py_b2 > bnd[G_BYHI]);
	assign sx_hi  = (px_b2 > SAT_HI);
	assign sx_lo  = (px_b2 < SAT_LO);
	assign sy_hi  = (py_b2 > SAT_HI);
	assign sy_lo  = (py_b2 < SAT_LO);

	// b3: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (ctl_b2.zero) begin
				cross_x <= '0;
				cross_y <= '0;
				status  <= ST_PARALLEL;
				is_hit  <= 1'b0;
			end else if (seg_mode && miss_a) begin
				cross_x <= '0;
				cross_y <= '0;
				status  <= ST_OUT_A;
				is_hit  <= 1'b0;
			end else if (seg_mode && miss_b) begin
				cross_x <= '0;
				cross_y <= '0;
				status  <= ST_OUT_B;
				is_hit  <= 1'b0;
			end else begin
				cross_x <= sx_hi ? OUT_W'(OUT_MAX) : sx_lo ? OUT_W'(OUT_MIN)
				                                          : px_b2[OUT_W-1:0];
				cross_y <= sy_hi ? OUT_W'(OUT_MAX) : sy_lo ? OUT_W'(OUT_MIN)
				                                          : py_b2[OUT_W-1:0];
				status  <= (sx_hi || sx_lo || sy_hi || sy_lo) ? ST_SAT : ST_HIT;
				is_hit  <= !(sx_hi || sx_lo || sy_hi || sy_lo);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/sgi_checker.sv
// ----------------------------------------------------------------------------
// sgi_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgi_checker import sgi_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic signed [OUT_W-1:0] cross_x,
	input wire logic signed [OUT_W-1:0] cross_y,
	input wire logic [2:0]              status,
	input wire logic                    is_hit
);

	a_hit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_hit == (status == ST_HIT)))
		else $error("is_hit disagrees with status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_PARALLEL || status == ST_OUT_A || status == ST_OUT_B)
		|-> (cross_x == '0) && (cross_y == '0))
		else $error("point not zero on a miss");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_HIT || status == ST_PARALLEL ||
		               status == ST_OUT_A || status == ST_OUT_B || status == ST_SAT))
		else $error("status out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cross_x) &&
		                           $stable(cross_y) && $stable(status))
		else $error("stalled beat changed");

endmodule

bind segment_intersection sgi_checker u_sgi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cross_x   (cross_x),
	.cross_y   (cross_y),
	.status    (status),
	.is_hit    (is_hit)
);

`default_nettype wire
